// File: src/dpd_pkg.sv
// Shared types and constants of the detection proposal decoder.
package dpd_pkg;

    localparam int BOX_CHANNELS    = 4;
    localparam int DEFAULT_CLASSES = 80;
    localparam int FRAC_SHIFT      = 33;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_CONF_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd5;

    localparam logic [16:0] RST_CONF_THRESHOLD = 17'd32768;
    localparam logic [7:0]  RST_CLASS_COUNT    = 8'd80;
    localparam logic [23:0] RST_X_SCALE        = 24'd65536;
    localparam logic [23:0] RST_Y_SCALE        = 24'd65536;
    localparam logic [13:0] RST_IMAGE_WIDTH    = 14'd640;
    localparam logic [13:0] RST_IMAGE_HEIGHT   = 14'd640;

    typedef struct packed {
        logic signed [31:0] channel_value;
        logic               last_channel;
        logic               frame_start;
    } dpd_in_t;

    typedef struct packed {
        logic [12:0] box_left;
        logic [12:0] box_top;
        logic [12:0] box_span_x;
        logic [12:0] box_span_y;
        logic [6:0]  class_index;
        logic [30:0] score;
        logic [15:0] proposal_number;
    } dpd_out_t;

    // Per-proposal values that ride along the edge pipeline unchanged.
    typedef struct packed {
        logic [6:0]  class_index;
        logic [30:0] score;
        logic [15:0] proposal_number;
    } dpd_tag_t;

    // A finished, kept proposal handed from the accumulator to the edge units.
    typedef struct packed {
        logic               valid;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] width;
        logic signed [31:0] height;
        dpd_tag_t           tag;
    } dpd_dec_t;

    // Load enables of the edge pipeline stages.
    typedef struct packed {
        logic sum;
        logic mul;
        logic clamp;
        logic outp;
    } dpd_pipe_ld_t;

endpackage

// File: src/dpd_accum.sv
// Per-proposal accumulator: box channels, running class maximum and numbering.
module dpd_accum import dpd_pkg::*; #(
    parameter int MAX_CLASSES   = 128,
    parameter int MAX_CHANNELS  = 512,
    parameter int MAX_PROPOSALS = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  dpd_in_t     in_word,
    input  logic        dec_take,
    input  logic [16:0] conf_threshold,
    input  logic [7:0]  class_count,
    output dpd_dec_t    dec
);

    localparam int CH_W   = $clog2(MAX_CHANNELS);
    localparam int CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CLS_XW = CLS_W + 7;
    localparam int CMP_W  = 16;
    localparam int PROP_LIM = (MAX_PROPOSALS > 65536) ? 65536 : MAX_PROPOSALS;
    localparam int PROP_W = (PROP_LIM > 1) ? $clog2(PROP_LIM) : 1;

    logic [CH_W-1:0]          cnt_reg, cnt_next;
    logic signed [31:0]       box_reg [BOX_CHANNELS];
    logic signed [31:0]       box_next [BOX_CHANNELS];
    logic [30:0]              best_reg, best_next;
    logic [CLS_W-1:0]         cls_reg, cls_next;
    logic [PROP_W-1:0]        prop_reg, prop_next;
    dpd_dec_t                 dec_reg, dec_next;

    logic [CMP_W-1:0]         cls_base, cls_eff, class_off;
    logic                     in_class, better, keep;
    logic [PROP_W-1:0]        number;
    logic [CLS_XW-1:0]        cls_wide;
    logic signed [31:0]       v;

    assign v = in_word.channel_value;

    always_comb begin
        cls_base  = (class_count == 8'd0) ? CMP_W'(DEFAULT_CLASSES) : CMP_W'(class_count);
        cls_eff   = (cls_base > CMP_W'(MAX_CLASSES)) ? CMP_W'(MAX_CLASSES) : cls_base;
        class_off = CMP_W'(cnt_reg) - CMP_W'(BOX_CHANNELS);
        in_class  = (cnt_reg >= CH_W'(BOX_CHANNELS)) && (class_off < cls_eff);
        better    = in_class && !v[31] && (v[30:0] > best_reg);
        number    = in_word.frame_start ? '0 : prop_reg;

        for (int i = 0; i < BOX_CHANNELS; i++) begin
            box_next[i] = box_reg[i];
        end
        if (cnt_reg < CH_W'(BOX_CHANNELS)) begin
            box_next[cnt_reg[1:0]] = v;
        end
        best_next = better ? v[30:0] : best_reg;
        cls_next  = better ? CLS_W'(class_off) : cls_reg;
        cnt_next  = (cnt_reg < CH_W'(MAX_CHANNELS - 1)) ? cnt_reg + 1'b1 : cnt_reg;
        keep      = best_next >= 31'(conf_threshold);
        cls_wide  = CLS_XW'(cls_next);

        dec_next = dec_reg;
        if (dec_take) begin
            dec_next.valid = 1'b0;
        end
        if (accept && in_word.last_channel) begin
            dec_next.valid                = keep;
            dec_next.center_x             = box_next[0];
            dec_next.center_y             = box_next[1];
            dec_next.width                = box_next[2];
            dec_next.height               = box_next[3];
            dec_next.tag.class_index      = cls_wide[6:0];
            dec_next.tag.score            = best_next;
            dec_next.tag.proposal_number  = 16'(number);
        end

        if (in_word.last_channel) begin
            prop_next = (number == PROP_W'(PROP_LIM - 1)) ? '0 : number + 1'b1;
        end else begin
            prop_next = number;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            best_reg  <= '0;
            cls_reg   <= '0;
            prop_reg  <= '0;
            dec_reg.valid <= 1'b0;
            for (int i = 0; i < BOX_CHANNELS; i++) begin
                box_reg[i] <= '0;
            end
        end else begin
            dec_reg.valid    <= dec_next.valid;
            dec_reg.center_x <= dec_next.center_x;
            dec_reg.center_y <= dec_next.center_y;
            dec_reg.width    <= dec_next.width;
            dec_reg.height   <= dec_next.height;
            dec_reg.tag      <= dec_next.tag;
            if (accept) begin
                prop_reg <= prop_next;
                if (in_word.last_channel) begin
                    // Every proposal starts from a clean slate, kept or not.
                    cnt_reg  <= '0;
                    best_reg <= '0;
                    cls_reg  <= '0;
                    for (int i = 0; i < BOX_CHANNELS; i++) begin
                        box_reg[i] <= '0;
                    end
                end else begin
                    cnt_reg  <= cnt_next;
                    best_reg <= best_next;
                    cls_reg  <= cls_next;
                    for (int i = 0; i < BOX_CHANNELS; i++) begin
                        box_reg[i] <= box_next[i];
                    end
                end
            end
        end
    end

    assign dec = dec_reg;

endmodule

// File: src/dpd_edge.sv
// Edge unit for one axis: scale the near and far edges, clamp and take the span.
module dpd_edge import dpd_pkg::*; #(
    parameter int MAX_IMAGE_DIM = 8192
) (
    input  logic               aclk,
    input  dpd_pipe_ld_t       ld,
    input  logic signed [31:0] center,
    input  logic signed [31:0] size_val,
    input  logic [23:0]        scale,
    input  logic [13:0]        image_size,
    output logic [12:0]        edge_px,
    output logic [12:0]        span_px
);

    localparam int IMG_W  = $clog2(MAX_IMAGE_DIM);
    localparam int SZ_W   = ($clog2(MAX_IMAGE_DIM + 1) > 14) ? $clog2(MAX_IMAGE_DIM + 1) : 14;
    localparam int SUM_W  = 34;
    localparam int PROD_W = 58;
    localparam int CL_W   = IMG_W + FRAC_SHIFT;
    localparam int PX_XW  = IMG_W + 13;

    logic signed [SUM_W-1:0]  c2, s_ext, lo_sum_next, hi_sum_next;
    logic signed [SUM_W-1:0]  lo_sum_reg, hi_sum_reg;
    logic signed [24:0]       scale_s;
    logic signed [PROD_W-1:0] lo_prod_next, hi_prod_next, lo_prod_reg, hi_prod_reg;
    logic [SZ_W-1:0]          size_ext, size_sat, lim_full;
    logic [CL_W-1:0]          lim, lo_cl_next, hi_cl_next, lo_cl_reg, hi_cl_reg;
    logic [CL_W:0]            diff;
    logic [PX_XW-1:0]         edge_wide, span_wide;
    logic [12:0]              edge_reg, span_reg;

    function automatic logic [CL_W-1:0] clamp_edge(logic signed [PROD_W-1:0] p,
                                                   logic [CL_W-1:0] limit);
        logic [CL_W-1:0] r;
        if (p[PROD_W-1]) begin
            r = '0;
        end else if (p[PROD_W-2:0] > (PROD_W-1)'(limit)) begin
            r = limit;
        end else begin
            r = p[CL_W-1:0];
        end
        return r;
    endfunction

    // The edges are kept in Q.33: twice the center plus or minus the size, times Q8.16.
    assign c2          = {center[31], center, 1'b0};
    assign s_ext       = SUM_W'(size_val);
    assign lo_sum_next = c2 - s_ext;
    assign hi_sum_next = c2 + s_ext;

    assign scale_s      = $signed({1'b0, scale});
    assign lo_prod_next = PROD_W'(lo_sum_reg) * PROD_W'(scale_s);
    assign hi_prod_next = PROD_W'(hi_sum_reg) * PROD_W'(scale_s);

    always_comb begin
        size_ext = SZ_W'(image_size);
        size_sat = (size_ext > SZ_W'(MAX_IMAGE_DIM)) ? SZ_W'(MAX_IMAGE_DIM) : size_ext;
        lim_full = (size_sat == '0) ? '0 : size_sat - 1'b1;
        lim      = {lim_full[IMG_W-1:0], {FRAC_SHIFT{1'b0}}};
    end

    assign lo_cl_next = clamp_edge(lo_prod_reg, lim);
    assign hi_cl_next = clamp_edge(hi_prod_reg, lim);

    assign diff      = {1'b0, hi_cl_reg} - {1'b0, lo_cl_reg};
    assign edge_wide = PX_XW'(lo_cl_reg[CL_W-1:FRAC_SHIFT]);
    assign span_wide = (hi_cl_reg > lo_cl_reg) ? PX_XW'(diff[CL_W-1:FRAC_SHIFT]) : '0;

    always_ff @(posedge aclk) begin
        if (ld.sum) begin
            lo_sum_reg <= lo_sum_next;
            hi_sum_reg <= hi_sum_next;
        end
        if (ld.mul) begin
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod_next;
        end
        if (ld.clamp) begin
            lo_cl_reg <= lo_cl_next;
            hi_cl_reg <= hi_cl_next;
        end
        if (ld.outp) begin
            edge_reg <= edge_wide[12:0];
            span_reg <= span_wide[12:0];
        end
    end

    assign edge_px = edge_reg;
    assign span_px = span_reg;

endmodule

// File: src/detection_proposal_decode.sv
// Top level of the detection proposal decoder: registers, pipeline control, result port.
//
// Usage: the input channel takes one detector output channel per word (signed Q15.16),
// proposal by proposal: center x, center y, width, height, then class_count class scores,
// then any further channels, which are ignored. last_channel closes a proposal and
// frame_start restarts the proposal numbering at zero with the current proposal.
// A closing word whose best class score reaches conf_threshold yields one result word
// with the clamped box, class, score and proposal number; other words yield nothing.
// Throughput: one input word per cycle, sustained while the receiver takes results. The
// accept edge of a closing word loads the accumulator output; the edge sum, multiply,
// clamp and span registers follow, and the last of them drives the result.
// When the receiver stalls, results back up through the five pipeline registers; the
// input keeps taking words while a bubble remains ahead of the accumulator output and
// only drops ready when that register holds a result that cannot move.
// Reset (synchronous, active low) empties the pipeline, clears the proposal state and
// numbering and loads the default register values. Registers are written through the
// plain write port and take effect at once; write them only while the block is idle.
module detection_proposal_decode import dpd_pkg::*; #(
    parameter int MAX_CLASSES   = 128,
    parameter int MAX_CHANNELS  = 512,
    parameter int MAX_PROPOSALS = 65536,
    parameter int MAX_IMAGE_DIM = 8192
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dpd_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dpd_out_t              m_data
);

    logic [16:0] conf_threshold_reg;
    logic [7:0]  class_count_reg;
    logic [23:0] x_scale_reg, y_scale_reg;
    logic [13:0] image_width_reg, image_height_reg;

    dpd_dec_t     dec;
    dpd_pipe_ld_t ld;
    logic         accept;
    logic         vb_reg, vc_reg, vd_reg, ve_reg;
    logic         ra, rb, rc, rd, re;
    dpd_tag_t     tag_b_reg, tag_c_reg, tag_d_reg, tag_e_reg;
    logic [12:0]  left_px, top_px, span_x_px, span_y_px;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conf_threshold_reg <= RST_CONF_THRESHOLD;
            class_count_reg    <= RST_CLASS_COUNT;
            x_scale_reg        <= RST_X_SCALE;
            y_scale_reg        <= RST_Y_SCALE;
            image_width_reg    <= RST_IMAGE_WIDTH;
            image_height_reg   <= RST_IMAGE_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CONF_THRESHOLD: conf_threshold_reg <= cfg_wdata[16:0];
                CFG_CLASS_COUNT:    class_count_reg    <= cfg_wdata[7:0];
                CFG_X_SCALE:        x_scale_reg        <= cfg_wdata[23:0];
                CFG_Y_SCALE:        y_scale_reg        <= cfg_wdata[23:0];
                CFG_IMAGE_WIDTH:    image_width_reg    <= cfg_wdata[13:0];
                CFG_IMAGE_HEIGHT:   image_height_reg   <= cfg_wdata[13:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves.
    assign re = !ve_reg || m_ready;
    assign rd = !vd_reg || re;
    assign rc = !vc_reg || rd;
    assign rb = !vb_reg || rc;
    assign ra = !dec.valid || rb;

    assign s_ready = ra;
    assign accept  = s_valid && s_ready;

    assign ld.sum   = rb;
    assign ld.mul   = rc;
    assign ld.clamp = rd;
    assign ld.outp  = re;

    dpd_accum #(
        .MAX_CLASSES  (MAX_CLASSES),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_PROPOSALS(MAX_PROPOSALS)
    ) u_accum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .in_word       (s_data),
        .dec_take      (rb),
        .conf_threshold(conf_threshold_reg),
        .class_count   (class_count_reg),
        .dec           (dec)
    );

    dpd_edge #(
        .MAX_IMAGE_DIM(MAX_IMAGE_DIM)
    ) u_edge_x (
        .aclk      (aclk),
        .ld        (ld),
        .center    (dec.center_x),
        .size_val  (dec.width),
        .scale     (x_scale_reg),
        .image_size(image_width_reg),
        .edge_px   (left_px),
        .span_px   (span_x_px)
    );

    dpd_edge #(
        .MAX_IMAGE_DIM(MAX_IMAGE_DIM)
    ) u_edge_y (
        .aclk      (aclk),
        .ld        (ld),
        .center    (dec.center_y),
        .size_val  (dec.height),
        .scale     (y_scale_reg),
        .image_size(image_height_reg),
        .edge_px   (top_px),
        .span_px   (span_y_px)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else begin
            if (rb) vb_reg <= dec.valid;
            if (rc) vc_reg <= vb_reg;
            if (rd) vd_reg <= vc_reg;
            if (re) ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rb) tag_b_reg <= dec.tag;
        if (rc) tag_c_reg <= tag_b_reg;
        if (rd) tag_d_reg <= tag_c_reg;
        if (re) tag_e_reg <= tag_d_reg;
    end

    assign m_valid                = ve_reg;
    assign m_data.box_left        = left_px;
    assign m_data.box_top         = top_px;
    assign m_data.box_span_x      = span_x_px;
    assign m_data.box_span_y      = span_y_px;
    assign m_data.class_index     = tag_e_reg.class_index;
    assign m_data.score           = tag_e_reg.score;
    assign m_data.proposal_number = tag_e_reg.proposal_number;

endmodule

// File: tb/sv/proposal_check_pkg.sv
// Scoreboard class that predicts decoded detection boxes and checks the result words.
package proposal_check_pkg;
    import dpd_pkg::*;

    localparam int CLASS_LIMIT   = 128;
    localparam int CHANNEL_LIMIT = 512;
    localparam int DIM_LIMIT     = 8192;

    class proposal_scoreboard;
        // Register copies.
        logic [16:0] min_score;
        logic [7:0]  class_channels;
        logic [23:0] scale_x;
        logic [23:0] scale_y;
        logic [13:0] width_px;
        logic [13:0] height_px;

        // Running proposal state.
        int unsigned        chan_pos;
        logic signed [31:0] box_word [4];
        logic signed [31:0] top_score;
        logic [6:0]         top_class;
        logic [15:0]        prop_num;

        dpd_out_t pending_boxes [$];
        int       errors;
        int       printed;

        function new();
            min_score      = RST_CONF_THRESHOLD;
            class_channels = RST_CLASS_COUNT;
            scale_x        = RST_X_SCALE;
            scale_y        = RST_Y_SCALE;
            width_px       = RST_IMAGE_WIDTH;
            height_px      = RST_IMAGE_HEIGHT;
            prop_num       = '0;
            errors         = 0;
            printed        = 0;
            clear_proposal();
        endfunction

        function void clear_proposal();
            chan_pos  = 0;
            box_word  = '{default: '0};
            top_score = '0;
            top_class = '0;
        endfunction

        function int pending_count();
            return pending_boxes.size();
        endfunction

        task report(string msg);
            errors++;
            if (printed < 100) begin
                printed++;
                $display("ERROR @%0t: %s", $time, msg);
            end
        endtask

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CONF_THRESHOLD: min_score      = data[16:0];
                CFG_CLASS_COUNT:    class_channels = data[7:0];
                CFG_X_SCALE:        scale_x        = data[23:0];
                CFG_Y_SCALE:        scale_y        = data[23:0];
                CFG_IMAGE_WIDTH:    width_px       = data[13:0];
                CFG_IMAGE_HEIGHT:   height_px      = data[13:0];
                default: ;
            endcase
        endfunction

        // Both edges are formed at 2^-33 resolution so that the half size needs no rounding.
        function void scale_edge(input logic signed [31:0] center, input logic signed [31:0] size,
                                 input logic [23:0] scale, input logic [13:0] extent,
                                 output logic [12:0] near, output logic [12:0] span);
            int unsigned dim;
            longint      bound;
            longint      lo;
            longint      hi;
            dim   = (extent > DIM_LIMIT) ? DIM_LIMIT : extent;
            bound = (dim > 0) ? (longint'(dim - 1) << FRAC_SHIFT) : 0;
            lo    = (2 * longint'(center) - longint'(size)) * longint'(scale);
            hi    = (2 * longint'(center) + longint'(size)) * longint'(scale);
            if (lo > bound) lo = bound;
            if (lo < 0) lo = 0;
            if (hi > bound) hi = bound;
            if (hi < 0) hi = 0;
            near = 13'(lo >>> FRAC_SHIFT);
            span = (hi > lo) ? 13'((hi - lo) >>> FRAC_SHIFT) : '0;
        endfunction

        function void note_channel(dpd_in_t word);
            int unsigned        classes;
            logic signed [31:0] value;
            dpd_out_t           box;
            value   = word.channel_value;
            classes = (class_channels == 0) ? DEFAULT_CLASSES :
                      ((class_channels > CLASS_LIMIT) ? CLASS_LIMIT : class_channels);
            if (word.frame_start) prop_num = '0;
            if (chan_pos < BOX_CHANNELS) begin
                box_word[chan_pos] = value;
            end else if (chan_pos - BOX_CHANNELS < classes && value > top_score) begin
                top_score = value;
                top_class = 7'(chan_pos - BOX_CHANNELS);
            end
            if (chan_pos < CHANNEL_LIMIT - 1) chan_pos++;
            if (word.last_channel) begin
                if (longint'(top_score) >= longint'(min_score)) begin
                    scale_edge(box_word[0], box_word[2], scale_x, width_px,
                               box.box_left, box.box_span_x);
                    scale_edge(box_word[1], box_word[3], scale_y, height_px,
                               box.box_top, box.box_span_y);
                    box.class_index     = top_class;
                    box.score           = 31'(top_score);
                    box.proposal_number = prop_num;
                    pending_boxes.insert(pending_boxes.size(), box);
                end
                prop_num++;
                clear_proposal();
            end
        endfunction

        task compare_field(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s is %0d, expected %0d", field, got, want));
        endtask

        task check_box(dpd_out_t got);
            dpd_out_t want;
            if (pending_boxes.size() == 0) begin
                report($sformatf("result word %h with no kept proposal pending", got));
                return;
            end
            want = pending_boxes.pop_front();
            compare_field("box_left", got.box_left, want.box_left);
            compare_field("box_top", got.box_top, want.box_top);
            compare_field("box_span_x", got.box_span_x, want.box_span_x);
            compare_field("box_span_y", got.box_span_y, want.box_span_y);
            compare_field("class_index", got.class_index, want.class_index);
            compare_field("score", got.score, want.score);
            compare_field("proposal_number", got.proposal_number, want.proposal_number);
        endtask

        task flush_missing();
            report($sformatf("%0d expected result words never arrived", pending_boxes.size()));
            pending_boxes.delete();
        endtask
    endclass

endpackage

// File: tb/sv/testbench.sv
// Top-level testbench of the detection proposal decoder: clock, reset, stimulus and checks.
module testbench;
    import dpd_pkg::*;
    import proposal_check_pkg::*;

    localparam int PIPE_DEPTH   = 5;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TIMEOUT      = 3000000;

    typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    dpd_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    dpd_out_t              m_data;

    proposal_scoreboard sb = new();

    int       cur_thr     = 32768;
    int       eff_classes = DEFAULT_CLASSES;
    int       burst_left  = 0;
    bit       steady      = 1'b0;
    int       hold_requests = 0;
    int       hold_seen   = 0;
    int       hold_left   = 0;
    int       mode_left   = 0;
    rx_mode_t rx_mode     = RX_OPEN;

    detection_proposal_decode #(
        .MAX_CLASSES  (CLASS_LIMIT),
        .MAX_CHANNELS (CHANNEL_LIMIT),
        .MAX_IMAGE_DIM(DIM_LIMIT)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_channel(s_data);
            if (m_valid && m_ready) sb.check_box(m_data);
        end
    end

    // The receiver switches between stall patterns and honors long hold-off requests.
    always @(negedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_HALF:   m_ready <= ($urandom_range(0, 1) == 0);
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge aclk);
        sb.set_register(idx, CFG_DATA_W'(value));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task configure(input int thr, input int classes, input int sx, input int sy,
                   input int w, input int h);
        write_reg(CFG_CONF_THRESHOLD, thr);
        write_reg(CFG_CLASS_COUNT, classes);
        write_reg(CFG_X_SCALE, sx);
        write_reg(CFG_Y_SCALE, sy);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        cur_thr     = thr & 32'h1FFFF;
        eff_classes = classes & 32'hFF;
        if (eff_classes == 0) eff_classes = DEFAULT_CLASSES;
        if (eff_classes > CLASS_LIMIT) eff_classes = CLASS_LIMIT;
    endtask

    // The sender idles for a random gap between bursts unless a steady stream is wanted.
    task send_word(input logic signed [31:0] value, input bit last, input bit fs);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 3) == 0 || steady) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid             <= 1'b1;
        s_data.channel_value <= value;
        s_data.last_channel  <= last;
        s_data.frame_start   <= fs;
        do @(posedge aclk); while (!s_ready);
    endtask

    function logic signed [31:0] box_value(bit is_size);
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh7FFFFFFF;
                    1:       v = 32'sh80000000;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            2: v = -int'($urandom_range(0, 60 << 16));
            default: v = is_size ? $urandom_range(0, 400 << 16) : $urandom_range(0, 800 << 16);
        endcase
        return v;
    endfunction

    // Quantized scores give frequent ties; others sit just below, at or just above the threshold.
    function logic signed [31:0] score_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: v = -int'($urandom_range(1, 1 << 20));
            2: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh7FFFFFFF;
                    1:       v = 32'sh80000000;
                    2:       v = '0;
                    default: v = 1;
                endcase
            end
            3, 4: v = cur_thr - 1 + $urandom_range(0, 2);
            default: v = $urandom_range(0, 8) * 8192;
        endcase
        return v;
    endfunction

    task send_proposal(output int len);
        int kind;
        int fs_at;
        logic signed [31:0] v;
        kind = $urandom_range(0, 19);
        if (kind < 14)
            len = BOX_CHANNELS + eff_classes +
                  (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        else if (kind < 17)
            len = $urandom_range(1, BOX_CHANNELS + eff_classes - 1);
        else
            len = BOX_CHANNELS + eff_classes + $urandom_range(4, 12);
        fs_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            if (i < BOX_CHANNELS) v = box_value(i >= 2);
            else if (i - BOX_CHANNELS < eff_classes) v = score_value();
            else v = $urandom;
            send_word(v, i == len - 1, i == fs_at || $urandom_range(0, 199) == 0);
        end
    endtask

    task wait_drain();
        int waited;
        @(negedge aclk);
        s_valid <= 1'b0;
        waited = 0;
        while (sb.pending_count() > 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (sb.pending_count() > 0) sb.flush_missing();
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task run_phase(input int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget) begin
            send_proposal(len);
            sent += len;
        end
        wait_drain();
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed proposals with two classes at unit scale.
        configure(32768, 2, 65536, 65536, 640, 640);
        send_word(100 << 16, 1'b0, 1'b1);
        send_word(200 << 16, 1'b0, 1'b0);
        send_word(50 << 16, 1'b0, 1'b0);
        send_word(40 << 16, 1'b0, 1'b0);
        send_word(49152, 1'b0, 1'b0);
        send_word(58982, 1'b1, 1'b0);
        // Extreme box words; equal scores keep the first class.
        send_word(32'sh7FFFFFFF, 1'b0, 1'b0);
        send_word(32'sh80000000, 1'b0, 1'b0);
        send_word(32'sh7FFFFFFF, 1'b0, 1'b0);
        send_word(32'sh80000000, 1'b0, 1'b0);
        send_word(39322, 1'b0, 1'b0);
        send_word(39322, 1'b1, 1'b0);
        // Negative width, score equal to the threshold, a trailing ignored channel,
        // and a frame start in the middle of the proposal.
        send_word(320 << 16, 1'b0, 1'b0);
        send_word(320 << 16, 1'b0, 1'b0);
        send_word(-(10 << 16), 1'b0, 1'b1);
        send_word(700 << 16, 1'b0, 1'b0);
        send_word(-1, 1'b0, 1'b0);
        send_word(32768, 1'b0, 1'b0);
        send_word(32'sh7FFFFFFF, 1'b1, 1'b0);
        // Proposal closed at its width channel, before its height and class channels.
        send_word(5 << 16, 1'b0, 1'b0);
        send_word(6 << 16, 1'b0, 1'b0);
        send_word(0, 1'b1, 1'b0);
        // Proposal closed at its first class channel, with the largest score.
        send_word(10 << 16, 1'b0, 1'b0);
        send_word(10 << 16, 1'b0, 1'b0);
        send_word(4 << 16, 1'b0, 1'b0);
        send_word(4 << 16, 1'b0, 1'b0);
        send_word(32'sh7FFFFFFF, 1'b1, 1'b0);
        wait_drain();

        // Every proposal is kept while the receiver holds off, so the block backs up.
        configure(0, 1, 65536, 65536, 640, 640);
        steady = 1'b1;
        hold_requests++;
        run_phase(100);
        steady = 1'b0;

        configure(0, 1, 0, 24'hFFFFFF, 1, 8192);
        run_phase(100);
        configure(65536, 3, 24'hFFFFFF, 0, 8192, 1);
        run_phase(100);
        configure($urandom_range(0, 65536), 0, $urandom_range(0, 24'hFFFFFF),
                  $urandom_range(16384, 262144), 16383, 0);
        run_phase(40);
        configure($urandom_range(0, 131071), 200, $urandom_range(16384, 262144),
                  $urandom_range(0, 24'hFFFFFF), 0, 16383);
        run_phase(40);
        configure(40000, 128, 131072, 32768, 1920, 1080);
        run_phase(40);

        // One proposal long enough to saturate the channel position.
        configure(0, 4, 65536, 65536, 640, 640);
        for (int i = 0; i < 515; i++) begin
            send_word((i < BOX_CHANNELS) ? box_value(i >= 2) :
                      ((i < 8) ? score_value() : $urandom), i == 514, 1'b0);
        end
        wait_drain();

        for (int p = 0; p < 5; p++) begin
            configure($urandom_range(0, 70000), $urandom_range(1, 8),
                      $urandom_range(0, 1) ? $urandom_range(0, 24'hFFFFFF)
                                           : $urandom_range(16384, 262144),
                      $urandom_range(0, 1) ? $urandom_range(0, 24'hFFFFFF)
                                           : $urandom_range(16384, 262144),
                      $urandom_range(1, 8192), $urandom_range(1, 8192));
            run_phase(60);
        end

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
